FILE: sv/seconds_to_calendar_datetime_core_assert.svh
// Assertion macros for the calendar conversion RTL
`ifndef SECONDS_TO_CALENDAR_DATETIME_CORE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATETIME_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define SECCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define SECCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/seccd_pkg.sv
// Constants, month table and shared types for the calendar conversion core
`default_nettype none

package seccd_pkg;

  localparam logic [31:0] LIMIT_SECONDS = 32'd3155760000;
  localparam logic [11:0] BASE_YEAR     = 12'd2000;

  // days = (secs >> 7) / 675, exact for any 25-bit operand
  localparam int          DAY_SHIFT  = 35;
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [9:0]  DAY_UNIT   = 10'd675;

  // year = (days * 4) / 1461, exact for every day count of a 32-bit input
  localparam int          YEAR_SHIFT = 28;
  localparam logic [17:0] YEAR_RECIP = 18'd183735;
  localparam logic [8:0]  DAYS_COMMON = 9'd365;

  // hour = (tod >> 4) / 225, exact for any 13-bit operand
  localparam int          HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // minute = (rem >> 2) / 15, exact for any 10-bit operand
  localparam int          MIN_SHIFT  = 14;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  localparam int NUM_LATE_MONTHS = 10;

  // Last day index of each month from March on, and the index just before it
  localparam logic [8:0] MONTH_TOP [NUM_LATE_MONTHS] = '{
    9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };
  localparam logic [8:0] MONTH_BASE [NUM_LATE_MONTHS] = '{
    9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] FEB_END    = 9'd59;
  localparam logic [8:0] DEC_BASE   = 9'd334;
  localparam logic [8:0] JAN_END_LEAP   = 9'd30;
  localparam logic [8:0] JAN_END_COMMON = 9'd31;
  localparam logic [3:0] MONTH_JAN  = 4'd1;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_MAR  = 4'd3;
  localparam logic [3:0] MONTH_DEC  = 4'd12;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } date_t;

endpackage

`default_nettype wire

FILE: sv/seconds_to_calendar_datetime_core.sv
// Top level: pipelined seconds-since-2000 to calendar date and time converter
//
//   channel   direction  handshake                      payload
//   seconds   in         seconds_valid / seconds_stall  seconds_since_2000
//   result    out        result_valid / result_stall    year..second, out_of_range
//
// Seven register stages, one beat per cycle unless a stalled result holds the pipe;
// the stages hold the constant multiplies, their subtracts and the month threshold compare.
// rst clears the stage valid bits only; payload registers load without reset.
// A stalled result freezes the whole pipe, so seconds_stall follows result_stall
// while a result is waiting.
`default_nettype none
`include "seconds_to_calendar_datetime_core_assert.svh"

module seconds_to_calendar_datetime_core
  import seccd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seconds_valid,
  output logic        seconds_stall,
  input  logic [31:0] seconds_since_2000,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        out_of_range
);

  localparam int NUM_STAGES = 7;

  logic                  advance;
  logic [NUM_STAGES-1:0] valid_pipe;

  // stage 1: whole days
  logic [31:0] s1_secs;
  logic [15:0] s1_days;
  logic        s1_oor;
  logic [50:0] day_prod;

  // stage 2: time of day
  logic [15:0] s2_days;
  logic [16:0] s2_tod;
  logic        s2_oor;
  logic [25:0] day_secs_prod;
  logic [24:0] tod_hi;

  // stage 3: year index
  logic [15:0] s3_days;
  logic [16:0] s3_tod;
  logic [6:0]  s3_yr;
  logic        s3_oor;
  logic [35:0] year_prod;

  // stage 4: day of year and hour
  logic [8:0]  s4_doy;
  logic        s4_leap;
  logic [6:0]  s4_yr;
  logic [16:0] s4_tod;
  logic [4:0]  s4_hh;
  logic        s4_oor;
  logic [15:0] year_start;
  logic [15:0] doy_wide;
  logic [26:0] hour_prod;

  // stage 5: month and day, seconds within the hour
  date_t       s5_date;
  date_t       date_dec;
  logic [6:0]  s5_yr;
  logic [4:0]  s5_hh;
  logic [11:0] s5_rem;
  logic        s5_oor;
  logic [16:0] hour_secs;
  logic [16:0] rem_wide;

  // stage 6: minute
  date_t       s6_date;
  logic [6:0]  s6_yr;
  logic [4:0]  s6_hh;
  logic [11:0] s6_rem;
  logic [5:0]  s6_mm;
  logic        s6_oor;
  logic [20:0] min_prod;

  logic [11:0] min_secs;
  logic [11:0] sec_wide;

  assign advance       = !(result_valid && result_stall);
  assign seconds_stall = !advance;
  assign result_valid  = valid_pipe[NUM_STAGES-1];

  assign day_prod      = 51'(seconds_since_2000[31:7]) * 51'(DAY_RECIP);
  assign day_secs_prod = 26'(s1_days) * 26'(DAY_UNIT);
  assign tod_hi        = s1_secs[31:7] - day_secs_prod[24:0];
  assign year_prod     = 36'({s2_days, 2'b00}) * 36'(YEAR_RECIP);
  assign year_start    = 16'(s3_yr) * 16'(DAYS_COMMON) + 16'(s3_yr[6:2]);
  assign doy_wide      = s3_days - year_start;
  assign hour_prod     = 27'(s3_tod[16:4]) * 27'(HOUR_RECIP);
  assign hour_secs     = 17'(s4_hh) * 17'(SECS_PER_HOUR);
  assign rem_wide      = s4_tod - hour_secs;
  assign min_prod      = 21'(s5_rem[11:2]) * 21'(MIN_RECIP);
  assign min_secs      = 12'(s6_mm) * 12'(SECS_PER_MIN);
  assign sec_wide      = s6_rem - min_secs;

  seccd_month_decode u_month (
    .doy  (s4_doy),
    .leap (s4_leap),
    .date (date_dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (advance) begin
      valid_pipe <= {valid_pipe[NUM_STAGES-2:0], seconds_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_secs <= seconds_since_2000;
      s1_days <= day_prod[DAY_SHIFT +: 16];
      s1_oor  <= seconds_since_2000 >= LIMIT_SECONDS;

      s2_days <= s1_days;
      s2_tod  <= {tod_hi[9:0], s1_secs[6:0]};
      s2_oor  <= s1_oor;

      s3_days <= s2_days;
      s3_tod  <= s2_tod;
      s3_yr   <= year_prod[YEAR_SHIFT +: 7];
      s3_oor  <= s2_oor;

      s4_doy  <= doy_wide[8:0];
      s4_leap <= s3_yr[1:0] == 2'b00;
      s4_yr   <= s3_yr;
      s4_tod  <= s3_tod;
      s4_hh   <= hour_prod[HOUR_SHIFT +: 5];
      s4_oor  <= s3_oor;

      s5_date <= date_dec;
      s5_yr   <= s4_yr;
      s5_hh   <= s4_hh;
      s5_rem  <= rem_wide[11:0];
      s5_oor  <= s4_oor;

      s6_date <= s5_date;
      s6_yr   <= s5_yr;
      s6_hh   <= s5_hh;
      s6_rem  <= s5_rem;
      s6_mm   <= min_prod[MIN_SHIFT +: 6];
      s6_oor  <= s5_oor;

      // drop every field to zero past the end of 2099
      out_of_range <= s6_oor;
      if (s6_oor) begin
        year   <= '0;
        month  <= '0;
        day    <= '0;
        hour   <= '0;
        minute <= '0;
        second <= '0;
      end else begin
        year   <= BASE_YEAR + 12'(s6_yr);
        month  <= s6_date.month;
        day    <= s6_date.day;
        hour   <= s6_hh;
        minute <= s6_mm;
        second <= sec_wide[5:0];
      end
    end
  end

  `SECCD_ASSERT_NEXT(a_accept_enters, seconds_valid && !seconds_stall, valid_pipe[0],
    "accepted beat did not enter the first stage")
  `SECCD_ASSERT_NOW(a_year_index, valid_pipe[2] && !s3_oor, s3_yr <= 7'd99,
    "year index beyond the century")
  `SECCD_ASSERT_NOW(a_doy_bound, valid_pipe[3] && !s4_oor, s4_doy <= 9'd366,
    "day of year out of bounds")
  `SECCD_ASSERT_NOW(a_oor_zero, result_valid && out_of_range,
    year == '0 && month == '0 && day == '0 && hour == '0 && minute == '0 && second == '0,
    "out of range result carries nonzero fields")
  `SECCD_ASSERT_NOW(a_fields_legal, result_valid && !out_of_range,
    year >= 12'd2000 && year <= 12'd2099 && month >= 4'd1 && month <= 4'd12 &&
    day >= 5'd1 && day <= 5'd31 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59,
    "result field out of its calendar range")

endmodule

`default_nettype wire

FILE: sv/seccd_month_decode.sv
// Day-of-year to month and day-of-month decoder
`default_nettype none

module seccd_month_decode
  import seccd_pkg::*;
(
  input  logic [8:0] doy,
  input  logic       leap,
  output date_t      date
);

  logic [8:0] day_wide;

  always_comb begin
    date.month = MONTH_DEC;
    day_wide   = doy - DEC_BASE;
    if (doy <= FEB_END) begin
      // leap years count from zero, common years from one
      if (leap) begin
        if (doy <= JAN_END_LEAP) begin
          day_wide   = doy + 9'd1;
          date.month = MONTH_JAN;
        end else begin
          day_wide   = doy - JAN_END_LEAP;
          date.month = MONTH_FEB;
        end
      end else begin
        if (doy <= JAN_END_COMMON) begin
          day_wide   = doy;
          date.month = MONTH_JAN;
        end else begin
          day_wide   = doy - JAN_END_COMMON;
          date.month = MONTH_FEB;
        end
      end
    end else begin
      // walk down so the lowest matching threshold wins
      for (int i = NUM_LATE_MONTHS - 1; i >= 0; i--) begin
        if (doy <= MONTH_TOP[i]) begin
          date.month = MONTH_MAR + 4'(i);
          day_wide   = doy - MONTH_BASE[i];
        end
      end
    end
    date.day = day_wide[4:0];
  end

endmodule

`default_nettype wire
